// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/bdq_pkg.sv -----
// Package with the sizes, operation codes and cell control type of the deque.
package bdq_pkg;

  // Number of storage cells in the chain.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Operation codes carried on the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_REAR  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_QUERY      = 3'd4
  } func_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                    shift_up;
    logic                    shift_down;
    logic                    load_rear;
    logic signed [VAL_W-1:0] push_value;
  } cell_ctl_t;

  // The deque is full once the count reaches min(capacity, DEPTH).
  function automatic logic is_full(input logic [CNT_W-1:0] count,
                                   input logic [CAP_W-1:0] cap);
    logic ge_cap;
    logic at_depth;
    ge_cap   = (CMP_W'(count) >= CMP_W'(cap));
    at_depth = (count == CNT_W'(DEPTH));
    return ge_cap || at_depth;
  endfunction

endpackage

// ----- design/bounded_deque.sv -----
// Top level of the bounded deque: control, cell chain and result register.
//
//  channel  | direction | fields (lowest bit first)
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: item_value[31:0]; tuser: func[2:0]
//  m_axis   | out       | tdata: ok, front_value, rear_value, empty_flag,
//           |           |        full_flag, zero pad to 72 bits
//  cfg      | in        | cfg_data_i: capacity[4:0]
//
// Each transaction updates the cells at the accepting edge, and its result is
// on m_axis in the next cycle. A new transaction is taken in the same cycle
// the pending result is taken, so while m_axis does not stall the block
// sustains one transaction per cycle; the rear read is a mux over the cell chain.
// Reset empties the deque and sets capacity to 16; cell contents are kept.
// A stall on m_axis holds s_axis_tready low until the result is taken.
module bounded_deque (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: tdata = item_value[31:0]; tuser = func[2:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  // Result stream: tdata = ok[0], front_value[32:1], rear_value[64:33],
  // empty_flag[65], full_flag[66], zeros[71:67].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  // Capacity register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned DEPTH = bdq_pkg::DEPTH;
  localparam int unsigned CNT_W = bdq_pkg::CNT_W;
  localparam int unsigned IDX_W = bdq_pkg::IDX_W;
  localparam int unsigned VAL_W = bdq_pkg::VAL_W;
  localparam int unsigned CAP_W = bdq_pkg::CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             ok_q, ok_d;
  logic             full_q, full_d;

  logic               accept;
  logic               full_now;
  logic               empty_now;
  logic               count_up, count_down;
  bdq_pkg::func_e     func;
  bdq_pkg::cell_ctl_t ctl;

  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic        [CNT_W-1:0] last_pos;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] rear_value;

  // Input handshake: free when no result waits or it leaves this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign func          = bdq_pkg::func_e'(s_axis_tuser);

  assign full_now  = bdq_pkg::is_full(count_q, cap_q);
  assign empty_now = (count_q == '0);

  // Decode the operation into cell control and count movement.
  always_comb begin
    ctl            = '0;
    ctl.push_value = s_axis_tdata;
    ok_d           = 1'b0;
    count_up       = 1'b0;
    count_down     = 1'b0;
    case (func)
      bdq_pkg::FN_PUSH_FRONT: begin
        if (!full_now) begin
          ctl.shift_up = accept;
          count_up     = 1'b1;
          ok_d         = 1'b1;
        end
      end
      bdq_pkg::FN_PUSH_REAR: begin
        if (!full_now) begin
          ctl.load_rear = accept;
          count_up      = 1'b1;
          ok_d          = 1'b1;
        end
      end
      bdq_pkg::FN_POP_FRONT: begin
        if (!empty_now) begin
          ctl.shift_down = accept;
          count_down     = 1'b1;
          ok_d           = 1'b1;
        end
      end
      bdq_pkg::FN_POP_REAR: begin
        if (!empty_now) begin
          count_down = 1'b1;
          ok_d       = 1'b1;
        end
      end
      bdq_pkg::FN_QUERY: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Entry count after the operation and the full flag that goes with it.
  always_comb begin
    count_d = count_q;
    if (count_up) begin
      count_d = count_q + 1'b1;
    end else if (count_down) begin
      count_d = count_q - 1'b1;
    end
    full_d = bdq_pkg::is_full(count_d, cap_q);
  end

  // Chain of cells; cell 0 holds the front entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;
    logic                    hit;

    if (i == 0) begin : g_first
      assign lower = s_axis_tdata;
    end else begin : g_inner_lo
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner_hi
      assign upper = cell_data[i+1];
    end

    assign hit = (count_q == CNT_W'(i));

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .hit_i   (hit),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  // Control registers and the pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_W'(16);
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        ok_q        <= ok_d;
        full_q      <= full_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Front and rear are read from the cells, which hold still until the
  // pending result is taken.
  assign last_pos    = count_q - 1'b1;
  assign front_value = empty_now ? '1 : cell_data[0];
  assign rear_value  = empty_now ? '1 : cell_data[last_pos[IDX_W-1:0]];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, full_q, empty_now, rear_value, front_value, ok_q};

endmodule

// ----- design/bdq_cell.sv -----
// One storage cell of the deque chain; takes data from either neighbor.
module bdq_cell (
  input  logic                             clk_i,
  input  bdq_pkg::cell_ctl_t               ctl_i,
  input  logic                             hit_i,
  input  logic signed [bdq_pkg::VAL_W-1:0] lower_i,
  input  logic signed [bdq_pkg::VAL_W-1:0] upper_i,
  output logic signed [bdq_pkg::VAL_W-1:0] data_o
);

  logic signed [bdq_pkg::VAL_W-1:0] data_q;
  logic signed [bdq_pkg::VAL_W-1:0] data_d;

  // Push front moves everything one cell toward the rear, pop front toward
  // the front, and a push rear writes only the cell just past the last entry.
  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      data_d = lower_i;
    end else if (ctl_i.shift_down) begin
      data_d = upper_i;
    end else if (ctl_i.load_rear && hit_i) begin
      data_d = ctl_i.push_value;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- design/bdq_checker.sv -----
// Port-level checker for the bounded deque, bound to the top level.
`include "assert_macros.svh"

module bdq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  logic in_txn;
  logic query_txn;
  logic empty_out;
  logic ends_all_ones;
  logic out_stall;

  assign in_txn        = s_axis_tvalid && s_axis_tready;
  assign query_txn     = in_txn && (s_axis_tuser == bdq_pkg::FN_QUERY);
  assign empty_out     = m_axis_tvalid && m_axis_tdata[65];
  assign ends_all_ones = (m_axis_tdata[32:1] == 32'hFFFF_FFFF) &&
                         (m_axis_tdata[64:33] == 32'hFFFF_FFFF);
  assign out_stall     = m_axis_tvalid && !m_axis_tready;

  // Every accepted transaction produces a result in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_txn, m_axis_tvalid)

  // A query always succeeds.
  `ASSERT_NEXT(a_query_ok, clk_i, rst_ni, query_txn, m_axis_tdata[0])

  // An empty deque reports -1 for both ends.
  `ASSERT_IMPLY(a_empty_ends, clk_i, rst_ni, empty_out, ends_all_ones)

  // A stalled result holds its contents.
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bounded_deque bdq_checker u_bdq_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking regression of the bounded deque: directed cases, backpressure and random phases.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_LAST_CODE = {bdq_pkg::FUNC_W{1'b1}};

  // Packed view of one result transaction, lowest field in the lowest bits.
  typedef struct packed {
    logic [4:0]                       pad;
    logic                             full;
    logic                             empty;
    logic signed [bdq_pkg::VAL_W-1:0] rear;
    logic signed [bdq_pkg::VAL_W-1:0] front;
    logic                             ok;
  } deque_status_t;

  // Stimulus mix used by the random phases.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;   // item_value[31:0]
  logic [2:0]        s_axis_tuser;   // func[2:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [71:0]       m_axis_tdata;   // ok, front_value, rear_value, empty, full, pad
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [4:0]        cfg_data_i;

  // Shadow copy of the deque contents and its capacity register.
  logic signed [bdq_pkg::VAL_W-1:0] ring [bdq_pkg::DEPTH];
  int unsigned                      head_ptr = 0;
  int unsigned                      fill_count = 0;
  logic [bdq_pkg::CAP_W-1:0]        cap_reg = bdq_pkg::CAP_W'(16);

  deque_status_t status_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int refused_ops = 0;
  int full_hits = 0;

  bounded_deque DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one operation to the shadow deque and return the status after it.
  task automatic deque_apply(input logic [bdq_pkg::FUNC_W-1:0] fn,
                             input logic signed [bdq_pkg::VAL_W-1:0] val,
                             output deque_status_t st);
    int unsigned bound;
    bound = (cap_reg > bdq_pkg::DEPTH) ? bdq_pkg::DEPTH : int'(cap_reg);
    st = '0;
    case (fn)
      bdq_pkg::FN_PUSH_FRONT: begin
        if (fill_count < bound) begin
          head_ptr = (head_ptr + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
          ring[head_ptr] = val;
          fill_count++;
          st.ok = 1'b1;
        end
      end
      bdq_pkg::FN_PUSH_REAR: begin
        if (fill_count < bound) begin
          ring[(head_ptr + fill_count) % bdq_pkg::DEPTH] = val;
          fill_count++;
          st.ok = 1'b1;
        end
      end
      bdq_pkg::FN_POP_FRONT: begin
        if (fill_count != 0) begin
          head_ptr = (head_ptr + 1) % bdq_pkg::DEPTH;
          fill_count--;
          st.ok = 1'b1;
        end
      end
      bdq_pkg::FN_POP_REAR: begin
        if (fill_count != 0) begin
          fill_count--;
          st.ok = 1'b1;
        end
      end
      bdq_pkg::FN_QUERY: st.ok = 1'b1;
      default: ;
    endcase
    // An empty deque reports -1 at both ends.
    if (fill_count != 0) begin
      st.front = ring[head_ptr];
      st.rear  = ring[(head_ptr + fill_count - 1) % bdq_pkg::DEPTH];
    end else begin
      st.front = -1;
      st.rear  = -1;
    end
    st.empty = (fill_count == 0);
    st.full  = (fill_count >= bound);
  endtask

  // Append one predicted status to the tail of the pending list.
  task automatic record_status(input deque_status_t st);
    status_q = {status_q, st};
  endtask

  // Track accepted configuration and input transactions.
  always @(posedge clk_i) begin
    deque_status_t st;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_reg = cfg_data_i;
        cfg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        deque_apply(s_axis_tuser, s_axis_tdata, st);
        record_status(st);
        items_sent++;
        if (!st.ok) refused_ops++;
        if (st.full && !st.empty) full_hits++;
      end
    end
  end

  // Compare every result transaction with the oldest predicted status.
  always @(posedge clk_i) begin
    deque_status_t want;
    deque_status_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (status_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: result with nothing pending: tdata=%h", m_axis_tdata);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d: expected ok=%b front=%0d rear=%0d empty=%b full=%b pad=%h",
                     results_seen, want.ok, want.front, want.rear, want.empty, want.full,
                     want.pad);
          if (error_count <= MAX_REPORTS)
            $display("       actual           ok=%b front=%0d rear=%0d empty=%b full=%b pad=%h",
                     got.ok, got.front, got.rear, got.empty, got.full, got.pad);
        end
      end
    end
  end

  // Result side ready: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d results pending", status_q.size());
      $display("bounded_deque regression: fail");
      $finish;
    end
  end

  // Offer one item and wait until the block takes it; tvalid stays high afterwards.
  task automatic send_op(input logic [bdq_pkg::FUNC_W-1:0] fn,
                         input logic [bdq_pkg::VAL_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering items and wait until every pending result has been taken.
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
  endtask

  // Write the capacity register once the block is idle.
  task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] cap);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [bdq_pkg::FUNC_W-1:0] pick_func(input op_mix_e mix);
    int r;
    int push_pct;
    r = $urandom_range(99);
    if (r < 4) begin
      return bdq_pkg::FUNC_W'($urandom_range(FN_LAST_CODE, bdq_pkg::FN_QUERY + 1));
    end
    if (r < 10) return bdq_pkg::FN_QUERY;
    case (mix)
      MIX_FILL:  push_pct = 78;
      MIX_DRAIN: push_pct = 22;
      default:   push_pct = 50;
    endcase
    if ($urandom_range(89) < push_pct)
      return $urandom_range(1) ? bdq_pkg::FN_PUSH_FRONT : bdq_pkg::FN_PUSH_REAR;
    return $urandom_range(1) ? bdq_pkg::FN_POP_FRONT : bdq_pkg::FN_POP_REAR;
  endfunction

  function automatic logic [bdq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Empty deque: query, refused pops and undefined operation codes.
  task automatic test_empty_deque();
    send_op(bdq_pkg::FN_QUERY, 32'h0);
    send_op(bdq_pkg::FN_POP_FRONT, 32'h5a5a_5a5a);
    send_op(bdq_pkg::FN_POP_REAR, 32'ha5a5_a5a5);
    for (int c = bdq_pkg::FN_QUERY + 1; c <= FN_LAST_CODE; c++) begin
      send_op(bdq_pkg::FUNC_W'(c), $urandom);
    end
  endtask

  // Both ends with extreme values, then drained back to empty.
  task automatic test_both_ends();
    send_op(bdq_pkg::FN_PUSH_FRONT, 32'h7fff_ffff);
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h8000_0000);
    send_op(bdq_pkg::FN_PUSH_FRONT, 32'hffff_ffff);
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h0000_0000);
    send_op(bdq_pkg::FN_QUERY, 32'h0);
    send_op(bdq_pkg::FN_POP_FRONT, 32'h0);
    send_op(bdq_pkg::FN_POP_REAR, 32'h0);
    send_op(bdq_pkg::FN_POP_FRONT, 32'h0);
    send_op(bdq_pkg::FN_POP_REAR, 32'h0);
  endtask

  // Capacity of one entry, and capacity zero where the deque is empty and full at once.
  task automatic test_tiny_capacity();
    write_capacity(bdq_pkg::CAP_W'(1));
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h1234_5678);
    send_op(bdq_pkg::FN_PUSH_FRONT, 32'h8765_4321);
    send_op(bdq_pkg::FN_POP_FRONT, 32'h0);
    write_capacity(bdq_pkg::CAP_W'(0));
    send_op(bdq_pkg::FN_PUSH_FRONT, 32'hdead_beef);
    send_op(bdq_pkg::FN_QUERY, 32'h0);
  endtask

  // Capacity lowered below the count: entries kept, pushes refused, pops still work.
  task automatic test_capacity_below_count();
    write_capacity(bdq_pkg::CAP_W'(16));
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h0000_0011);
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h0000_0022);
    send_op(bdq_pkg::FN_PUSH_FRONT, 32'h0000_0033);
    write_capacity(bdq_pkg::CAP_W'(2));
    send_op(bdq_pkg::FN_PUSH_REAR, 32'h0000_0044);
    send_op(bdq_pkg::FN_POP_REAR, 32'h0);
    send_op(bdq_pkg::FN_POP_REAR, 32'h0);
  endtask

  // Long hold-off on the result side while items keep coming, so the input stalls.
  task automatic test_backpressure();
    write_capacity(bdq_pkg::CAP_W'(16));
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 150;
    for (int i = 0; i < 40; i++) send_op(pick_func(MIX_FILL), pick_value());
  endtask

  // The sender pauses until every result is back, then resumes.
  task automatic test_sender_pause();
    idle_pct = 33;
    stall_pct = 33;
    for (int i = 0; i < 15; i++) send_op(pick_func(MIX_EVEN), pick_value());
    wait_drain();
    for (int i = 0; i < 15; i++) send_op(pick_func(MIX_DRAIN), pick_value());
  endtask

  // One random phase at a given capacity and idling profile.
  task automatic test_random_phase(input int n, input logic [bdq_pkg::CAP_W-1:0] cap,
                                   input int idle, input int stall);
    op_mix_e mix;
    mix = MIX_EVEN;
    write_capacity(cap);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      // Switch the mix in bursts so the deque swings between empty and full.
      if (i % 24 == 0) mix = op_mix_e'($urandom_range(2));
      send_op(pick_func(mix), pick_value());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_deque();
    test_both_ends();
    test_tiny_capacity();
    test_capacity_below_count();
    test_backpressure();
    test_sender_pause();
    test_random_phase(150, bdq_pkg::CAP_W'(16), 0, 0);
    test_random_phase(150, bdq_pkg::CAP_W'(31), 67, 0);
    test_random_phase(150, bdq_pkg::CAP_W'(5), 0, 67);
    test_random_phase(110, bdq_pkg::CAP_W'(1), 33, 33);
    test_random_phase(100, bdq_pkg::CAP_W'(17), 0, 0);
    test_random_phase(40, bdq_pkg::CAP_W'(0), 33, 33);
    test_random_phase(60, bdq_pkg::CAP_W'(16), 33, 33);

    wait_drain();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d operations and %0d results over %0d capacity writes.",
             items_sent, results_seen, cfg_writes);
    $display("Refused operations: %0d, full non-empty states: %0d, mismatches: %0d.",
             refused_ops, full_hits, error_count);
    if (error_count == 0 && status_q.size() == 0) begin
      $display("bounded_deque regression: pass");
    end else begin
      $display("bounded_deque regression: fail");
    end
    $finish;
  end

endmodule
